[rtl/core/vdr_pkg.sv]
// Package for the vertex deduplication and index remap block.
// Holds table sizes, key field widths, opcodes, error codes and the command and status structs.
// No dependencies.
package vdr_pkg;

    localparam int TABLE_DEPTH    = 1024;
    localparam int IDX_W          = $clog2(TABLE_DEPTH);
    localparam int CNT_W          = IDX_W + 1;
    localparam int KEY_FIELD_BITS = 21;
    localparam int KEY_W          = 3 * KEY_FIELD_BITS;
    localparam int SCALE_W        = 20;
    localparam int COORD_W        = 32;
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(100000);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMAP  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_RANGE = 2'd2,
        ERR_RSVD  = 2'd3
    } t_err;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture input beat and start quantizing
        logic probe;      // read the key-store entry at the pointer and advance it
        logic ins_key;    // write key as new unique entry
        logic ins_map;    // write old-to-new map entry
        logic map_rd;     // read map at old_index
        logic clear;      // zero both counters
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;        // probed entry matches the key
        logic probe_end;  // probe pointer reached unique_count
        logic full;       // table full
        logic range_err;  // old_index >= inserted_count
    } t_sts;

endpackage

[rtl/core/vdr_datapath.sv]
// Datapath: quantizer, key store, map store, counters and result fields.
// Depends on vdr_pkg.
module vdr_datapath import vdr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [SCALE_W-1:0]  i_scale,
    input  logic [COORD_W-1:0]  i_coord_x,
    input  logic [COORD_W-1:0]  i_coord_y,
    input  logic [COORD_W-1:0]  i_coord_z,
    input  logic [IDX_W-1:0]    i_old_index,
    output t_sts                o_sts,
    output logic [IDX_W-1:0]    o_probe_idx,
    output logic [IDX_W-1:0]    o_map_data,
    output logic [IDX_W-1:0]    o_uniq_idx
);

    localparam int MAG_W  = COORD_W;
    localparam int PROD_W = MAG_W + SCALE_W;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << 29;
    localparam logic [KEY_FIELD_BITS-1:0] OFFSET = KEY_FIELD_BITS'(1) << (KEY_FIELD_BITS - 1);

    logic [KEY_W-1:0]   key_store [TABLE_DEPTH];
    logic [IDX_W-1:0]   map_store [TABLE_DEPTH];

    logic [CNT_W-1:0]   r_uniq_cnt, r_ins_cnt;
    logic [MAG_W-1:0]   r_mag [3];
    logic [2:0]         r_neg;
    logic [PROD_W-1:0]  r_prod [3];
    logic [2:0]         r_neg2;
    logic [KEY_W-1:0]   r_key;
    logic [KEY_W-1:0]   r_rd_key;
    logic [CNT_W-1:0]   r_ptr;
    logic [IDX_W-1:0]   r_rd_ptr;
    logic               r_rd_vld;
    logic [IDX_W-1:0]   r_map_data;
    logic [IDX_W-1:0]   r_idx_w;
    logic [KEY_FIELD_BITS-1:0] fld [3];
    logic [COORD_W-1:0] coord [3];

    assign coord[0] = i_coord_x;
    assign coord[1] = i_coord_y;
    assign coord[2] = i_coord_z;

    // Stage 1: magnitude and sign; stage 2: multiply; key forms from stage 2.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.load) begin
                r_neg[k] <= coord[k][COORD_W-1];
                r_mag[k] <= coord[k][COORD_W-1] ? (MAG_W'(0) - coord[k]) : coord[k];
            end
            r_prod[k] <= r_mag[k] * PROD_W'(i_scale) + HALF;
            r_neg2[k] <= r_neg[k];
        end
    end

    // Rounded quotient, offset and wrap into one key field each.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            fld[k] = r_neg2[k] ? (OFFSET - r_prod[k][30 +: KEY_FIELD_BITS])
                               : (OFFSET + r_prod[k][30 +: KEY_FIELD_BITS]);
        end
    end

    // Key register, probe pointer and one registered key-store read per probe cycle.
    always_ff @(posedge i_clk) begin
        if (!i_cmd.probe && !i_cmd.ins_key) begin
            r_key <= {fld[2], fld[1], fld[0]};
        end
        if (i_cmd.load) begin
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.probe) begin
            r_rd_key <= key_store[r_ptr[IDX_W-1:0]];
            r_rd_ptr <= r_ptr[IDX_W-1:0];
            r_rd_vld <= (r_ptr < r_uniq_cnt);
            r_ptr    <= r_ptr + CNT_W'(1);
        end
        if (i_cmd.ins_key) begin
            key_store[r_uniq_cnt[IDX_W-1:0]] <= r_key;
        end
        if (i_cmd.ins_map) begin
            map_store[r_ins_cnt[IDX_W-1:0]] <= r_idx_w;
        end
        if (i_cmd.map_rd) begin
            r_map_data <= map_store[i_old_index];
        end
    end

    // Index written to the map: the fresh unique index or the hit entry.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_key) begin
            r_idx_w <= r_uniq_cnt[IDX_W-1:0];
        end else if (r_rd_vld && r_rd_key == r_key) begin
            r_idx_w <= r_rd_ptr;
        end
    end

    // Counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_uniq_cnt <= '0;
            r_ins_cnt  <= '0;
        end else begin
            if (i_cmd.ins_key) r_uniq_cnt <= r_uniq_cnt + CNT_W'(1);
            if (i_cmd.ins_map) r_ins_cnt  <= r_ins_cnt + CNT_W'(1);
        end
    end

    // The last stored key is compared in the same cycle that the pointer reaches the count.
    assign o_sts.hit       = r_rd_vld && (r_rd_key == r_key);
    assign o_sts.probe_end = (r_ptr >= r_uniq_cnt);
    assign o_sts.full      = (r_ins_cnt >= CNT_W'(TABLE_DEPTH)) ||
                             (r_uniq_cnt >= CNT_W'(TABLE_DEPTH));
    assign o_sts.range_err = (CNT_W'(i_old_index) >= r_ins_cnt);
    assign o_probe_idx     = r_rd_ptr;
    assign o_map_data      = r_map_data;
    assign o_uniq_idx      = r_uniq_cnt[IDX_W-1:0];

endmodule

[rtl/core/vdr_ctrl.sv]
// Controller: sequences quantize, probe, insert and remap steps, holds the
// output beat. Depends on vdr_pkg.
module vdr_ctrl import vdr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_op,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [IDX_W-1:0] o_new_index,
    output logic             o_is_new,
    output logic [1:0]       o_error,
    output t_cmd             o_cmd,
    input  t_sts             i_sts,
    input  logic [IDX_W-1:0] i_probe_idx,
    input  logic [IDX_W-1:0] i_map_data,
    input  logic [IDX_W-1:0] i_uniq_idx
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_KEY, S_PROBE, S_MAP, S_REMAP, S_DONE
    } t_state;

    t_state           r_state;
    logic             r_vld;
    logic [IDX_W-1:0] r_idx;
    logic             r_new;
    logic [1:0]       r_err;
    logic             accept;
    logic             out_free;
    logic             fin_now;
    logic             set_vld;

    assign out_free   = !r_vld || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    // Beats answered at once: clear, unused opcode, table full, index out of range.
    assign fin_now = accept && !((i_op == OP_INSERT) && !i_sts.full)
                            && !((i_op == OP_REMAP) && !i_sts.range_err);
    assign set_vld = fin_now || ((r_state == S_DONE) && out_free);

    // Commands decoded from state and status.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load   = accept && (i_op == OP_INSERT) && !i_sts.full;
                o_cmd.map_rd = accept && (i_op == OP_REMAP);
                o_cmd.clear  = accept && (i_op == OP_CLEAR);
            end
            S_PROBE: begin
                o_cmd.probe   = !i_sts.hit && !i_sts.probe_end;
                o_cmd.ins_key = !i_sts.hit && i_sts.probe_end;
            end
            S_MAP:  o_cmd.ins_map = 1'b1;
            S_MUL, S_KEY, S_REMAP, S_DONE: ;
            default: ;
        endcase
    end

    // State and output beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= 1'b0;
        end else begin
            if (set_vld) begin
                r_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_idx <= '0;
                        r_new <= 1'b0;
                        case (i_op)
                            OP_INSERT: begin
                                if (i_sts.full) begin
                                    r_err <= ERR_FULL;
                                end else begin
                                    r_err   <= ERR_OK;
                                    r_state <= S_MUL;
                                end
                            end
                            OP_REMAP: begin
                                if (i_sts.range_err) begin
                                    r_err <= ERR_RANGE;
                                end else begin
                                    r_err   <= ERR_OK;
                                    r_state <= S_REMAP;
                                end
                            end
                            default: r_err <= ERR_OK;
                        endcase
                    end
                end
                S_MUL:   r_state <= S_KEY;
                S_KEY:   r_state <= S_PROBE;
                S_PROBE: begin
                    if (i_sts.hit) begin
                        r_idx   <= i_probe_idx;
                        r_state <= S_MAP;
                    end else if (i_sts.probe_end) begin
                        r_idx   <= i_uniq_idx;
                        r_new   <= 1'b1;
                        r_state <= S_MAP;
                    end
                end
                S_MAP:   r_state <= S_DONE;
                S_REMAP: begin
                    r_idx   <= i_map_data;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_vld;
    assign o_new_index = r_idx;
    assign o_is_new    = r_new;
    assign o_error     = r_err;

endmodule

[rtl/core/vertex_dedup_index_remap_top.sv]
// Channel   | Dir | Beat fields (low bit up)
// s_axis    | in  | tdata: op[1:0], coord_x[33:2], coord_y[65:34], coord_z[97:66],
//           |     |        old_index[107:98], zero pad to 112
// m_axis    | out | tdata: new_index[9:0], is_new[10], error[12:11], pad to 16
// cfg       | in  | quant_scale[19:0]
// An insert steps through the multiply, key, probe, map and done states (linear
// search of the key store, one registered read per cycle); remap through remap
// and done; clear, no-op and errors answer at once. Reset is synchronous and
// empties both counters; memories are not cleared. One item is in flight; a
// held output beat blocks the next accept. Top level: controller, datapath, scale
// register. Depends on vdr_pkg, vdr_ctrl and vdr_datapath.
module vertex_dedup_index_remap_top import vdr_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [111:0]  s_axis_tdata,   // op, coord_x, coord_y, coord_z, old_index
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [15:0]   m_axis_tdata,   // new_index, is_new, error
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [19:0]   i_cfg_data
);

    logic [SCALE_W-1:0] r_scale;
    t_cmd               cmd;
    t_sts               sts;
    logic [IDX_W-1:0]   probe_idx, map_data, uniq_idx, new_index;
    logic               is_new;
    logic [1:0]         err;

    // Scale register.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            r_scale <= i_cfg_data;
        end
    end

    vdr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_op        (s_axis_tdata[1:0]),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_new_index (new_index),
        .o_is_new    (is_new),
        .o_error     (err),
        .o_cmd       (cmd),
        .i_sts       (sts),
        .i_probe_idx (probe_idx),
        .i_map_data  (map_data),
        .i_uniq_idx  (uniq_idx)
    );

    vdr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_scale     (r_scale),
        .i_coord_x   (s_axis_tdata[33:2]),
        .i_coord_y   (s_axis_tdata[65:34]),
        .i_coord_z   (s_axis_tdata[97:66]),
        .i_old_index (s_axis_tdata[107:98]),
        .o_sts       (sts),
        .o_probe_idx (probe_idx),
        .o_map_data  (map_data),
        .o_uniq_idx  (uniq_idx)
    );

    assign m_axis_tdata = {3'b000, err, is_new, new_index};

endmodule
